### src/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared sizes, codes, types and helpers of the polyphonic step sequencer.
// ----------------------------------------------------------------------------
package pss_pkg;

   localparam int NUM_TRACKS = 4;
   localparam int STEP_COUNT = 32;

   localparam int TRK_W  = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
   localparam int CNT_W  = $clog2(NUM_TRACKS + 1);
   localparam int STEP_W = $clog2(STEP_COUNT);
   localparam int LEN_W  = $clog2(STEP_COUNT + 1);
   localparam int CELLS  = NUM_TRACKS * STEP_COUNT;
   localparam int ADDR_W = $clog2(CELLS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request codes
   localparam logic [3:0] REQ_TICK      = 4'd0;
   localparam logic [3:0] REQ_NOTE_ON   = 4'd1;
   localparam logic [3:0] REQ_NOTE_OFF  = 4'd2;
   localparam logic [3:0] REQ_START     = 4'd3;
   localparam logic [3:0] REQ_STOP      = 4'd4;
   localparam logic [3:0] REQ_CONTINUE  = 4'd5;
   localparam logic [3:0] REQ_SWITCH    = 4'd6;
   localparam logic [3:0] REQ_REC_BEGIN = 4'd7;
   localparam logic [3:0] REQ_DUB_BEGIN = 4'd8;
   localparam logic [3:0] REQ_REC_END   = 4'd9;
   localparam logic [3:0] REQ_REST      = 4'd10;
   localparam logic [3:0] REQ_TIE       = 4'd11;

   // message kinds
   localparam logic [2:0] MSG_NOTE_ON  = 3'd0;
   localparam logic [2:0] MSG_NOTE_OFF = 3'd1;
   localparam logic [2:0] MSG_START    = 3'd2;
   localparam logic [2:0] MSG_STOP     = 3'd3;
   localparam logic [2:0] MSG_TICK     = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_TICKS_PER_STEP = 2'd0;
   localparam logic [1:0] CSR_MIDI_CHANNEL   = 2'd1;
   localparam logic [1:0] CSR_CLOCK_INTERNAL = 2'd2;

   localparam logic [7:0] CELL_EMPTY   = 8'hff;
   localparam logic [7:0] TIE_FLAG     = 8'h80;
   localparam logic [7:0] TIE_REQ      = 8'hfe;
   localparam logic [7:0] KEY_DEFAULT  = 8'd60;
   localparam logic [6:0] SEQ_VELOCITY = 7'd100;

   typedef struct packed {
      logic [3:0] code;
      logic [6:0] note;
      logic [6:0] vel;
      logic       src;
      logic       sw;
   } item_type;

   typedef struct packed {
      logic [6:0] tps;
      logic [3:0] chan;
      logic       clk_int;
   } cfg_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] note;
      logic [6:0] vel;
   } msg_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [TRK_W-1:0] trk,
                                                   input logic [STEP_W-1:0] step);
      int a;
      a = int'(trk) * STEP_COUNT + int'(step);
      return a[ADDR_W-1:0];
   endfunction

endpackage

### src/pss_front.sv
// ----------------------------------------------------------------------------
// pss_front
// Accepts request items, drops unknown codes and note items on a foreign
// channel, and queues the rest for the sequencer core.
// ----------------------------------------------------------------------------
module pss_front import pss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [3:0]  req_tuser,
   input  logic [23:0] req_tdata,
   output logic        item_valid,
   input  logic        item_ready,
   output item_type    item
);

   item_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   item_type            in_item;
   logic [3:0]          in_chan;
   logic                keep, push, pop;

   always_comb begin
      in_item.code = req_tuser;
      in_item.note = req_tdata[6:0];
      in_item.vel  = req_tdata[13:7];
      in_chan      = req_tdata[17:14];
      in_item.src  = req_tdata[18];
      in_item.sw   = req_tdata[19];
      // unknown codes and note items on a foreign channel do nothing
      keep = (in_item.code <= REQ_TIE) &&
             !((in_item.code inside {REQ_NOTE_ON, REQ_NOTE_OFF}) && in_chan != cfg.chan);
   end

   assign req_tready = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign item_valid = cnt_ff != '0;
   assign item       = q_ff[rd_ff];
   assign push       = req_tvalid && req_tready && keep;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_in  = push ? QPTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? QPTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = QCNT_W'(cnt_ff + QCNT_W'(push) - QCNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= in_item;
      end
   end

endmodule

### src/pss_back.sv
// ----------------------------------------------------------------------------
// pss_back
// Sequencer core: pattern memory, playback and record state, message output.
// ----------------------------------------------------------------------------
module pss_back import pss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     item_valid,
   output logic     item_ready,
   input  item_type item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output msg_type  rsp_msg,
   output logic     rsp_last
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RD       = 4'd1;
   localparam logic [3:0] S_REL      = 4'd2;
   localparam logic [3:0] S_ON       = 4'd3;
   localparam logic [3:0] S_STEP_END = 4'd4;
   localparam logic [3:0] S_WR       = 4'd5;
   localparam logic [3:0] S_REC_END  = 4'd6;
   localparam logic [3:0] S_STOP     = 4'd7;
   localparam logic [3:0] S_STOP_END = 4'd8;
   localparam logic [3:0] S_FIN      = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   item_type          cur_ff, cur_in;
   logic              rec_op_ff, rec_op_in, pass_ff, pass_in;
   logic [7:0]        rec_nt_ff, rec_nt_in;

   logic              running_ff, running_in, recording_ff, recording_in;
   logic              dubbing_ff, dubbing_in;
   logic [6:0]        tick_ff, tick_in;
   logic [STEP_W-1:0] play_ff, play_in, edit_ff, edit_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [7:0]        root_ff, root_in, latest_ff, latest_in, prev_ff, prev_in;
   logic [7:0]        raw_ff [NUM_TRACKS];
   logic [7:0]        raw_in [NUM_TRACKS];
   logic [7:0]        shifted_ff [NUM_TRACKS];
   logic [7:0]        shifted_in [NUM_TRACKS];
   logic [7:0]        row_ff [NUM_TRACKS];
   logic [7:0]        row_in [NUM_TRACKS];

   logic [7:0]        mem [CELLS];
   logic              vld_ff [CELLS];
   logic [7:0]        rd_data_ff;
   logic              rd_vld_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;

   logic              pend_valid_ff, pend_valid_in;
   msg_type           pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   msg_type           out_ff, out_in;

   logic              emit, flush, out_free, can_emit;
   msg_type           emit_msg;

   // record helpers
   logic [7:0]        rec_data, rec_prev;
   logic [7:0]        new_row [NUM_TRACKS];
   logic [7:0]        base_row [NUM_TRACKS];
   logic              placed;

   logic [TRK_W-1:0]  idx, idx_m1;
   logic [CNT_W-1:0]  cnt_m1;
   logic              cnt_at_end, tied;
   logic [6:0]        tick_nx;
   logic [STEP_W:0]   step_nx;
   logic              start_req, stop_req, set_key;
   logic [7:0]        cur_cell, shifted;

   assign out_free = !out_valid_ff || rsp_ready;
   assign can_emit = !pend_valid_ff || out_free;
   assign cnt_m1   = cnt_ff - 1'b1;
   assign idx      = cnt_ff[TRK_W-1:0];
   assign idx_m1   = cnt_m1[TRK_W-1:0];
   assign cnt_at_end = cnt_ff == CNT_W'(NUM_TRACKS - 1);
   assign cur_cell = row_ff[idx];
   assign shifted  = cur_cell + latest_ff - root_ff;

   always_comb begin
      tied = 1'b0;
      for (int u = 0; u < NUM_TRACKS; u++) begin
         if (row_ff[u] == (raw_ff[idx] | TIE_FLAG)) begin
            tied = 1'b1;
         end
      end
   end

   always_comb begin
      rec_data = rec_nt_ff;
      rec_prev = prev_ff;
      if (rec_nt_ff == TIE_REQ && prev_ff != CELL_EMPTY) begin
         rec_data = TIE_FLAG | prev_ff;
      end else if (rec_nt_ff == CELL_EMPTY) begin
         rec_data = CELL_EMPTY;
      end else begin
         rec_prev = rec_nt_ff;
      end
      placed = 1'b0;
      for (int t = 0; t < NUM_TRACKS; t++) begin
         base_row[t] = recording_ff ? CELL_EMPTY : row_ff[t];
         new_row[t]  = base_row[t];
      end
      // first free track takes the note, track 0 when the step is full
      if (rec_data != CELL_EMPTY) begin
         for (int t = 0; t < NUM_TRACKS; t++) begin
            if (!placed && base_row[t] == CELL_EMPTY) begin
               new_row[t] = rec_data;
               placed     = 1'b1;
            end
         end
         if (!placed) begin
            new_row[0] = rec_data;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      rec_op_in    = rec_op_ff;
      pass_in      = pass_ff;
      rec_nt_in    = rec_nt_ff;
      running_in   = running_ff;
      recording_in = recording_ff;
      dubbing_in   = dubbing_ff;
      tick_in      = tick_ff;
      play_in      = play_ff;
      edit_in      = edit_ff;
      len_in       = len_ff;
      root_in      = root_ff;
      latest_in    = latest_ff;
      prev_in      = prev_ff;
      raw_in       = raw_ff;
      shifted_in   = shifted_ff;
      row_in       = row_ff;
      item_ready   = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = '0;
      emit         = 1'b0;
      emit_msg     = '0;
      flush        = 1'b0;
      start_req    = 1'b0;
      stop_req     = 1'b0;
      set_key      = 1'b0;
      tick_nx      = tick_ff + 1'b1;
      step_nx      = '0;

      case (state_ff)
         S_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               cur_in   = item;
               state_in = S_FIN;
               cnt_in   = '0;
               case (item.code)
                  REQ_TICK: begin
                     if (item.src == cfg.clk_int && running_ff) begin
                        if (cfg.clk_int) begin
                           emit          = 1'b1;
                           emit_msg.kind = MSG_TICK;
                        end
                        if (tick_nx < cfg.tps) begin
                           tick_in = tick_nx;
                        end else begin
                           tick_in   = '0;
                           rec_op_in = 1'b0;
                           state_in  = S_RD;
                        end
                     end
                  end
                  REQ_NOTE_ON: begin
                     if (recording_ff || dubbing_ff) begin
                        rec_op_in = 1'b1;
                        pass_in   = !running_ff;
                        rec_nt_in = {1'b0, item.note};
                        state_in  = S_RD;
                     end else if (running_ff && cfg.clk_int &&
                                  {1'b0, item.note} == latest_ff) begin
                        stop_req = 1'b1;
                     end else if (cfg.clk_int) begin
                        start_req = 1'b1;
                        set_key   = 1'b1;
                     end else begin
                        if (!running_ff) begin
                           emit          = 1'b1;
                           emit_msg.kind = MSG_NOTE_ON;
                           emit_msg.note = {1'b0, item.note};
                           emit_msg.vel  = item.vel;
                        end else begin
                           latest_in = {1'b0, item.note};
                        end
                     end
                  end
                  REQ_NOTE_OFF: begin
                     if (!running_ff) begin
                        emit          = 1'b1;
                        emit_msg.kind = MSG_NOTE_OFF;
                        emit_msg.note = {1'b0, item.note};
                        emit_msg.vel  = item.vel;
                     end
                  end
                  REQ_START: start_req = !cfg.clk_int;
                  REQ_STOP: stop_req = !cfg.clk_int;
                  REQ_CONTINUE: start_req = 1'b1;
                  REQ_SWITCH: begin
                     start_req = item.sw;
                     stop_req  = !item.sw;
                  end
                  REQ_REC_BEGIN: begin
                     edit_in      = '0;
                     recording_in = 1'b1;
                     dubbing_in   = 1'b0;
                     len_in       = '0;
                     prev_in      = CELL_EMPTY;
                  end
                  REQ_DUB_BEGIN: begin
                     edit_in      = '0;
                     recording_in = 1'b0;
                     dubbing_in   = 1'b1;
                     prev_in      = CELL_EMPTY;
                  end
                  REQ_REC_END: begin
                     recording_in = 1'b0;
                     dubbing_in   = 1'b0;
                  end
                  REQ_REST, REQ_TIE: begin
                     if (recording_ff || dubbing_ff) begin
                        rec_op_in = 1'b1;
                        pass_in   = 1'b0;
                        rec_nt_in = (item.code == REQ_REST) ? CELL_EMPTY : TIE_REQ;
                        state_in  = S_RD;
                     end
                  end
                  default: ;
               endcase
               if (start_req && !running_ff) begin
                  if (cfg.clk_int) begin
                     emit          = 1'b1;
                     emit_msg.kind = MSG_START;
                  end
                  tick_in    = cfg.tps - 1'b1;
                  root_in    = KEY_DEFAULT;
                  latest_in  = KEY_DEFAULT;
                  running_in = 1'b1;
                  play_in    = '0;
                  for (int t = 0; t < NUM_TRACKS; t++) begin
                     raw_in[t] = CELL_EMPTY;
                  end
               end
               if (set_key) begin
                  root_in   = {1'b0, item.note};
                  latest_in = {1'b0, item.note};
               end
               if (stop_req && running_ff) begin
                  running_in = 1'b0;
                  state_in   = S_STOP;
               end
            end
         end
         S_RD: begin
            // one read issued a cycle, its data lands in the cycle after
            if (cnt_ff != CNT_W'(NUM_TRACKS)) begin
               mem_raddr = cell_addr(idx, rec_op_ff ? edit_ff : play_ff);
            end
            if (cnt_ff != '0) begin
               row_in[idx_m1] = rd_vld_ff ? rd_data_ff : CELL_EMPTY;
            end
            if (cnt_ff == CNT_W'(NUM_TRACKS)) begin
               cnt_in   = '0;
               state_in = rec_op_ff ? S_WR : S_REL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_REL: begin
            if (raw_ff[idx] != CELL_EMPTY && !tied) begin
               if (can_emit) begin
                  emit          = 1'b1;
                  emit_msg.kind = MSG_NOTE_OFF;
                  emit_msg.note = shifted_ff[idx];
                  raw_in[idx]   = CELL_EMPTY;
               end
            end
            if (!(raw_ff[idx] != CELL_EMPTY && !tied) || can_emit) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_at_end) begin
                  cnt_in   = '0;
                  state_in = S_ON;
               end
            end
         end
         S_ON: begin
            if (cur_cell < TIE_FLAG) begin
               if (can_emit) begin
                  emit            = 1'b1;
                  emit_msg.kind   = MSG_NOTE_ON;
                  emit_msg.note   = shifted;
                  emit_msg.vel    = SEQ_VELOCITY;
                  raw_in[idx]     = cur_cell;
                  shifted_in[idx] = shifted;
               end
            end
            if (!(cur_cell < TIE_FLAG) || can_emit) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_at_end) begin
                  cnt_in   = '0;
                  state_in = S_STEP_END;
               end
            end
         end
         S_STEP_END: begin
            step_nx = {1'b0, play_ff} + 1'b1;
            if (step_nx >= len_ff || step_nx >= (STEP_W+1)'(STEP_COUNT)) begin
               step_nx = '0;
            end
            play_in  = step_nx[STEP_W-1:0];
            state_in = S_FIN;
         end
         S_WR: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(idx, edit_ff);
            mem_wdata = new_row[idx];
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_at_end) begin
               cnt_in   = '0;
               state_in = S_REC_END;
            end
         end
         S_REC_END: begin
            prev_in = rec_prev;
            step_nx = {1'b0, edit_ff} + 1'b1;
            if (step_nx >= (STEP_W+1)'(STEP_COUNT)) begin
               step_nx = '0;
            end
            if (dubbing_ff && step_nx >= len_ff) begin
               step_nx = '0;
            end
            edit_in = step_nx[STEP_W-1:0];
            if (recording_ff) begin
               len_in = LEN_W'(step_nx);
            end
            if (pass_ff) begin
               emit          = 1'b1;
               emit_msg.kind = MSG_NOTE_ON;
               emit_msg.note = {1'b0, cur_ff.note};
               emit_msg.vel  = cur_ff.vel;
            end
            state_in = S_FIN;
         end
         S_STOP: begin
            if (raw_ff[idx] != CELL_EMPTY) begin
               if (can_emit) begin
                  emit          = 1'b1;
                  emit_msg.kind = MSG_NOTE_OFF;
                  emit_msg.note = shifted_ff[idx];
               end
            end
            if (raw_ff[idx] == CELL_EMPTY || can_emit) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_at_end) begin
                  cnt_in   = '0;
                  state_in = S_STOP_END;
               end
            end
         end
         S_STOP_END: begin
            if (!cfg.clk_int) begin
               state_in = S_FIN;
            end else if (can_emit) begin
               emit          = 1'b1;
               emit_msg.kind = MSG_STOP;
               state_in      = S_FIN;
            end
         end
         S_FIN: begin
            // held message goes out marked as the item's last
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               flush    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if ((emit && pend_valid_ff) || flush) begin
         out_valid_in = 1'b1;
         out_in       = pend_ff;
         out_last_in  = flush;
      end
      if (emit) begin
         pend_valid_in = 1'b1;
         pend_in       = emit_msg;
      end else if (flush) begin
         pend_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_msg   = out_ff;
   assign rsp_last  = out_last_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
      rd_vld_ff  <= vld_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CELLS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (mem_we) begin
         vld_ff[mem_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         running_ff    <= 1'b0;
         recording_ff  <= 1'b0;
         dubbing_ff    <= 1'b0;
         tick_ff       <= '0;
         play_ff       <= '0;
         edit_ff       <= '0;
         len_ff        <= '0;
         root_ff       <= KEY_DEFAULT;
         latest_ff     <= KEY_DEFAULT;
         prev_ff       <= CELL_EMPTY;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int t = 0; t < NUM_TRACKS; t++) begin
            raw_ff[t] <= CELL_EMPTY;
         end
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         running_ff    <= running_in;
         recording_ff  <= recording_in;
         dubbing_ff    <= dubbing_in;
         tick_ff       <= tick_in;
         play_ff       <= play_in;
         edit_ff       <= edit_in;
         len_ff        <= len_in;
         root_ff       <= root_in;
         latest_ff     <= latest_in;
         prev_ff       <= prev_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         raw_ff        <= raw_in;
      end
      cur_ff      <= cur_in;
      rec_op_ff   <= rec_op_in;
      pass_ff     <= pass_in;
      rec_nt_ff   <= rec_nt_in;
      shifted_ff  <= shifted_in;
      row_ff      <= row_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

endmodule

### src/poly_step_sequencer.sv
// ----------------------------------------------------------------------------
// poly_step_sequencer
// Polyphonic step sequencer: a request queue feeding a sequencer core.
// ----------------------------------------------------------------------------
// channel | ports      | dir | payload
// request | req_t*     | in  | tuser: req_type[3:0]
//         |            |     | tdata: note[6:0] velocity[13:7] event_channel[17:14]
//         |            |     |        tick_src[18] switch_value[19]
// result  | rsp_t*     | out | tuser: msg_kind[2:0]
//         |            |     | tdata: out_note[7:0] out_velocity[14:8]; tlast: last
// config  | csr_*      | in  | csr_index, csr_data
//
// A step runs a row read through the registered memory port, a release pass
// and a note-on pass in the core; a recorded item runs a row read and a row
// write.
// One message leaves per cycle at most; a stalled result stalls the core,
// while the request queue keeps taking items until it is full.
// Reset is synchronous; the pattern memory reads empty at once via per-cell
// valid bits.
// ----------------------------------------------------------------------------
module poly_step_sequencer import pss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [3:0]  req_tuser,   // req_type
   input  logic [23:0] req_tdata,   // note, velocity, event_channel,
                                    // tick_src, switch_value, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // msg_kind
   output logic [15:0] rsp_tdata,   // out_note, out_velocity, zero pad
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);

   cfg_type  cfg_ff;
   logic     item_valid, item_ready;
   item_type item;
   msg_type  rsp_msg;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tps     <= 7'd6;
         cfg_ff.chan    <= 4'd0;
         cfg_ff.clk_int <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TICKS_PER_STEP: cfg_ff.tps     <= csr_data;
            CSR_MIDI_CHANNEL:   cfg_ff.chan    <= csr_data[3:0];
            CSR_CLOCK_INTERNAL: cfg_ff.clk_int <= csr_data[0];
            default: ;
         endcase
      end
   end

   pss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   pss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_msg    (rsp_msg),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tuser = rsp_msg.kind;
   assign rsp_tdata = {1'b0, rsp_msg.vel, rsp_msg.note};

endmodule

### src/pss_checker.sv
// ----------------------------------------------------------------------------
// pss_port_checks
// Port-level checks on the result channel of the step sequencer.
// ----------------------------------------------------------------------------
module pss_port_checks import pss_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [2:0]  rsp_tuser,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result item dropped or changed under stall");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= MSG_TICK && rsp_tdata[15] == 1'b0)
      else $error("bad message kind or padding");

   a_clock_msg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == MSG_START || rsp_tuser == MSG_STOP ||
                     rsp_tuser == MSG_TICK) |-> rsp_tdata[14:0] == 15'd0)
      else $error("clock message carries note or velocity");

endmodule

bind poly_step_sequencer pss_port_checks u_pss_port_checks (.*);

### verif/pss_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pss_checker
// Watches the request, result and register channels of the step sequencer,
// predicts the messages of every accepted item and compares them in order.
// ----------------------------------------------------------------------------
module pss_checker import pss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [3:0]  req_tuser,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [2:0]  rsp_tuser,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      msg_type m;
      logic    last;
   } due_msg_type;

   due_msg_type due_msgs[$];

   logic [6:0] tps;
   logic [3:0] chan;
   logic       clk_int;

   logic [7:0] grid[CELLS];
   int         pat_len;
   logic       running, recording, dubbing;
   logic [6:0] tick_cnt;
   int         play_pos, edit_pos;
   logic [7:0] root_key, latest_key, prev_note;
   logic [7:0] held_raw[NUM_TRACKS];
   logic [7:0] held_shift[NUM_TRACKS];

   function automatic void push_msg(logic [2:0] kind, logic [7:0] nt, logic [6:0] vel);
      due_msg_type d;
      d.m.kind = kind;
      d.m.note = nt;
      d.m.vel  = vel;
      d.last   = 1'b0;
      due_msgs.push_back(d);
   endfunction

   function automatic void clear_state();
      tps = 7'd6;
      chan = 4'd0;
      clk_int = 1'b1;
      foreach (grid[i]) grid[i] = CELL_EMPTY;
      pat_len = 0;
      running = 0;
      recording = 0;
      dubbing = 0;
      tick_cnt = '0;
      play_pos = 0;
      edit_pos = 0;
      root_key = KEY_DEFAULT;
      latest_key = KEY_DEFAULT;
      prev_note = CELL_EMPTY;
      foreach (held_raw[t]) begin
         held_raw[t] = CELL_EMPTY;
         held_shift[t] = '0;
      end
   endfunction

   function automatic void seq_begin();
      if (running) return;
      if (clk_int) push_msg(MSG_START, 8'd0, 7'd0);
      tick_cnt = tps - 7'd1;
      root_key = KEY_DEFAULT;
      latest_key = KEY_DEFAULT;
      running = 1;
      play_pos = 0;
      foreach (held_raw[t]) held_raw[t] = CELL_EMPTY;
   endfunction

   function automatic void seq_halt();
      if (!running) return;
      running = 0;
      for (int t = 0; t < NUM_TRACKS; t++)
         if (held_raw[t] != CELL_EMPTY) push_msg(MSG_NOTE_OFF, held_shift[t], 7'd0);
      if (clk_int) push_msg(MSG_STOP, 8'd0, 7'd0);
   endfunction

   function automatic void step_advance();
      logic       tied;
      logic [7:0] cell_val;
      tick_cnt = tick_cnt + 7'd1;
      if (tick_cnt < tps) return;
      tick_cnt = '0;
      // release notes not tied over into this step
      for (int t = 0; t < NUM_TRACKS; t++) begin
         if (held_raw[t] != CELL_EMPTY) begin
            tied = 0;
            for (int u = 0; u < NUM_TRACKS; u++)
               if (grid[u*STEP_COUNT + play_pos] == (held_raw[t] | TIE_FLAG)) tied = 1;
            if (!tied) begin
               push_msg(MSG_NOTE_OFF, held_shift[t], 7'd0);
               held_raw[t] = CELL_EMPTY;
            end
         end
      end
      for (int t = 0; t < NUM_TRACKS; t++) begin
         cell_val = grid[t*STEP_COUNT + play_pos];
         if (cell_val < TIE_FLAG) begin
            held_raw[t] = cell_val;
            held_shift[t] = cell_val + latest_key - root_key;
            push_msg(MSG_NOTE_ON, held_shift[t], SEQ_VELOCITY);
         end
      end
      play_pos++;
      if (play_pos >= pat_len || play_pos >= STEP_COUNT) play_pos = 0;
   endfunction

   function automatic void record_cell(logic [7:0] nt);
      logic [7:0] data;
      logic       placed;
      data = nt;
      if (nt == TIE_REQ && prev_note != CELL_EMPTY) data = TIE_FLAG | prev_note;
      else if (nt == CELL_EMPTY) data = CELL_EMPTY;
      else prev_note = nt;
      if (recording)
         for (int t = 0; t < NUM_TRACKS; t++) grid[t*STEP_COUNT + edit_pos] = CELL_EMPTY;
      if (data != CELL_EMPTY) begin
         placed = 0;
         for (int t = 0; t < NUM_TRACKS; t++) begin
            if (!placed && grid[t*STEP_COUNT + edit_pos] == CELL_EMPTY) begin
               grid[t*STEP_COUNT + edit_pos] = data;
               placed = 1;
            end
         end
         // full step: track 0 gets overwritten
         if (!placed) grid[edit_pos] = data;
      end
      edit_pos++;
      if (edit_pos >= STEP_COUNT) edit_pos = 0;
      if (dubbing && edit_pos >= pat_len) edit_pos = 0;
      if (recording) pat_len = edit_pos;
   endfunction

   function automatic void predict_item(item_type it, logic [3:0] ch);
      int   first;
      logic prior_run, fresh_start;
      first = due_msgs.size();
      case (it.code)
         REQ_TICK: begin
            if (it.src == clk_int && running) begin
               if (clk_int) push_msg(MSG_TICK, 8'd0, 7'd0);
               step_advance();
            end
         end
         REQ_NOTE_ON: begin
            if (ch == chan) begin
               prior_run = running;
               fresh_start = 0;
               if (recording || dubbing) record_cell({1'b0, it.note});
               else if (running && clk_int && {1'b0, it.note} == latest_key) seq_halt();
               else if (clk_int) begin
                  seq_begin();
                  root_key = {1'b0, it.note};
                  fresh_start = 1;
               end
               if (!prior_run && !fresh_start) push_msg(MSG_NOTE_ON, {1'b0, it.note}, it.vel);
               if (running && !recording && !dubbing) latest_key = {1'b0, it.note};
            end
         end
         REQ_NOTE_OFF: if (ch == chan && !running) push_msg(MSG_NOTE_OFF, {1'b0, it.note}, it.vel);
         REQ_START:    if (!clk_int) seq_begin();
         REQ_STOP:     if (!clk_int) seq_halt();
         REQ_CONTINUE: if (!running) seq_begin();
         REQ_SWITCH:   if (it.sw) seq_begin(); else seq_halt();
         REQ_REC_BEGIN: begin
            edit_pos = 0;
            recording = 1;
            dubbing = 0;
            pat_len = 0;
            prev_note = CELL_EMPTY;
         end
         REQ_DUB_BEGIN: begin
            edit_pos = 0;
            recording = 0;
            dubbing = 1;
            prev_note = CELL_EMPTY;
         end
         REQ_REC_END: begin
            recording = 0;
            dubbing = 0;
         end
         REQ_REST: if (recording || dubbing) record_cell(CELL_EMPTY);
         REQ_TIE:  if (recording || dubbing) record_cell(TIE_REQ);
         default: ;
      endcase
      if (due_msgs.size() > first) due_msgs[due_msgs.size()-1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      due_msg_type d;
      item_type    it;
      if (reset) begin
         clear_state();
         due_msgs.delete();
         errors = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_msgs.size() == 0) begin
               $display("%0t: unexpected item kind %0d note %0d vel %0d last %0b", $time,
                        rsp_tuser, rsp_tdata[7:0], rsp_tdata[14:8], rsp_tlast);
               errors++;
            end else begin
               d = due_msgs.pop_front();
               if (rsp_tuser !== d.m.kind || rsp_tdata[7:0] !== d.m.note ||
                   rsp_tdata[14:8] !== d.m.vel || rsp_tlast !== d.last) begin
                  $display("%0t: expected kind %0d note %0d vel %0d last %0b, got kind %0d note %0d vel %0d last %0b",
                           $time, d.m.kind, d.m.note, d.m.vel, d.last, rsp_tuser,
                           rsp_tdata[7:0], rsp_tdata[14:8], rsp_tlast);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TICKS_PER_STEP: tps = csr_data;
               CSR_MIDI_CHANNEL:   chan = csr_data[3:0];
               CSR_CLOCK_INTERNAL: clk_int = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            it.code = req_tuser;
            it.note = req_tdata[6:0];
            it.vel  = req_tdata[13:7];
            it.src  = req_tdata[18];
            it.sw   = req_tdata[19];
            predict_item(it, req_tdata[17:14]);
         end
      end
      pending = due_msgs.size();
   end

endmodule

### verif/poly_step_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// poly_step_sequencer_tb
// Drives directed and random MIDI event sequences into the step sequencer
// across several register settings and idling patterns; the checker beside
// the block predicts and compares every message.
// ----------------------------------------------------------------------------
module poly_step_sequencer_tb import pss_pkg::*; ();

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 300;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [3:0]  req_tuser;
   logic [23:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [2:0]  rsp_tuser;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [6:0]  csr_data;
   int          errors, pending;

   int   send_idle, recv_idle;
   int   hold_left, cycles, sent;
   logic hold_start;
   logic [3:0] cur_chan;
   logic       cur_int;

   poly_step_sequencer dut (.*);

   pss_checker chk (.*);

   initial begin
      clock = 0;
      reset = 1;
      req_tvalid = 0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 0;
      csr_valid = 0;
      csr_index = CSR_TICKS_PER_STEP;
      csr_data = '0;
      send_idle = 0;
      recv_idle = 0;
      hold_left = 0;
      hold_start = 0;
      cycles = 0;
      sent = 0;
   end

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left = 400;
         hold_start = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   task automatic send(logic [3:0] code, logic [6:0] nt, logic [6:0] vel, logic [3:0] ch,
                       logic src, logic sw);
      req_tuser <= code;
      req_tdata <= {4'd0, sw, src, ch, vel, nt};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_note(logic [6:0] nt);
      send(REQ_NOTE_ON, nt, 7'($urandom), cur_chan, 1'($urandom), 1'($urandom));
   endtask

   task automatic send_tick();
      send(REQ_TICK, 7'($urandom), 7'($urandom), 4'($urandom), cur_int, 1'($urandom));
   endtask

   task automatic send_plain(logic [3:0] code, logic sw);
      send(code, 7'($urandom), 7'($urandom), 4'($urandom), 1'($urandom), sw);
   endtask

   // block idle: nothing queued, nothing owed, then room for silent items
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_regs(logic [6:0] tps, logic [3:0] ch, logic ci);
      logic [6:0] vals[3];
      logic [1:0] idx[3];
      vals = '{tps, {3'd0, ch}, {6'd0, ci}};
      idx = '{CSR_TICKS_PER_STEP, CSR_MIDI_CHANNEL, CSR_CLOCK_INTERNAL};
      for (int i = 0; i < 3; i++) begin
         csr_index <= idx[i];
         csr_data <= vals[i];
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      cur_chan = ch;
      cur_int = ci;
   endtask

   task automatic record_run(int len);
      int r;
      send_plain(($urandom_range(0, 2) == 0) ? REQ_DUB_BEGIN : REQ_REC_BEGIN, 0);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 9);
         if (r < 6) send_note(7'($urandom));
         else if (r < 8) send_plain(REQ_TIE, 0);
         else send_plain(REQ_REST, 0);
      end
      send_plain(REQ_REC_END, 0);
   endtask

   task automatic play_run();
      int n;
      if (cur_int) send_note(7'($urandom_range(48, 72)));
      else send_plain(($urandom_range(0, 1) == 0) ? REQ_START : REQ_CONTINUE, 0);
      n = $urandom_range(3, 20);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) send_note(7'($urandom_range(48, 72)));
         else send_tick();
      end
      if ($urandom_range(0, 1) == 0) send_plain(REQ_SWITCH, 1'b0);
      else send_plain(cur_int ? REQ_SWITCH : REQ_STOP, 1'b0);
   endtask

   task automatic random_phase(int target);
      int stop_at, r;
      stop_at = sent + target;
      while (sent < stop_at) begin
         r = $urandom_range(0, 9);
         if (r < 3) begin
            record_run($urandom_range(1, 8));
         end else if (r < 7) begin
            play_run();
         end else begin
            repeat ($urandom_range(1, 3))
               send(4'($urandom), 7'($urandom), 7'($urandom), 4'($urandom),
                    1'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      cur_chan = 4'd0;
      cur_int = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults of six ticks a step, channel 0, internal clock
      send_idle = 35;
      recv_idle = 76;
      send(4'd12, 7'd0, 7'd0, 4'd0, 1'b0, 1'b0);
      send(4'd15, 7'h7f, 7'h7f, 4'hf, 1'b1, 1'b1);
      send(REQ_NOTE_OFF, 7'd127, 7'd127, 4'd0, 1'b0, 1'b0);
      send(REQ_NOTE_ON, 7'd0, 7'd0, 4'd15, 1'b0, 1'b0);    // foreign channel
      send(REQ_NOTE_ON, 7'd127, 7'd127, 4'd0, 1'b1, 1'b1); // starts playback
      send(REQ_SWITCH, 7'd0, 7'd0, 4'd0, 1'b0, 1'b0);
      send_plain(REQ_REST, 0);
      send_plain(REQ_TIE, 0);
      send_plain(REQ_REC_END, 0);
      send_plain(REQ_REC_BEGIN, 0);
      send_plain(REQ_TIE, 0);                              // tie before any note
      send_note(7'd60);
      send_note(7'd62);
      send_plain(REQ_REC_END, 0);
      send_plain(REQ_DUB_BEGIN, 0);                        // dubs two items onto each of the three steps
      send_note(7'd64);
      send_note(7'd0);
      send_plain(REQ_TIE, 0);
      send_note(7'd127);
      send_note(7'd67);
      send_note(7'd69);
      send_plain(REQ_REC_END, 0);
      send_plain(REQ_START, 0);                            // ignored on internal clock
      send_note(7'd60);
      send(REQ_TICK, 7'd0, 7'd0, 4'd0, 1'b0, 1'b0);        // wrong source
      repeat (7) send_tick();
      send_note(7'd65);
      repeat (7) send_tick();
      send_note(7'd65);                                    // latest key stops
      send_plain(REQ_CONTINUE, 0);
      send_plain(REQ_STOP, 0);
      send_plain(REQ_SWITCH, 1'b0);
      drain();

      set_regs(7'd1, 4'd15, 1'b1);
      send_idle = 35;
      recv_idle = 76;
      hold_start = 1;
      random_phase(15);
      drain();

      set_regs(7'd96, 4'd7, 1'b0);
      send_idle = 76;
      recv_idle = 35;
      random_phase(15);
      drain();

      set_regs(7'd3, 4'd0, 1'b1);
      send_idle = 0;
      recv_idle = 0;
      record_run(33);                                      // wraps the edit position
      play_run();
      drain();

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
